### design/slr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package slr_pkg;

    // outputs per input frame at most
    localparam int unsigned MAX_OUTS = 8;
    localparam int unsigned CNT_BITS = $clog2(MAX_OUTS + 1);

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;     // take a new frame, form the differences
        logic mul;      // multiply by the phase, advance the phase
        logic emit;     // load the output word
        logic last;     // output word is the last of its frame
        logic finish;   // drop the phase by one, saturating at zero, keep the frame
    } slr_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic phase_lt_one;
        logic out_free;
    } slr_stat_t;

endpackage
`default_nettype wire

### design/slr_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface slr_frame_if #(
    parameter int W = 24
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] in_left;
    logic signed [W-1:0] in_right;

    modport source (output valid, output in_left, output in_right, input ready);
    modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

interface slr_result_if #(
    parameter int W = 24
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] out_left;
    logic signed [W-1:0] out_right;
    logic                last_of_run;

    modport source (output valid, output out_left, output out_right, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_left, input out_right, input last_of_run,
                    output ready);
endinterface

interface slr_cfg_if #(
    parameter int W = 20
);
    logic         valid;
    logic         ready;
    logic [W-1:0] step_ratio;

    modport source (output valid, output step_ratio, input ready);
    modport sink   (input valid, input step_ratio, output ready);
endinterface
`default_nettype wire

### design/stereo_linear_resampler.sv
// stereo linear-interpolation sample-rate converter
// channels: samples (sink) takes one stereo frame per word, in_left/in_right;
// results (source) gives interpolated words out_left/out_right with
// last_of_run set on the final word caused by a frame; cfg (sink) writes
// step_ratio, the unsigned phase increment per output, always ready.
// a frame makes zero to eight output words depending on the phase and step.
// sequence: a frame is accepted in idle; each output word takes a multiply
// step and an output-load step of the sequencer, one word at a time, and
// a frame ends with a phase-drop step before the sequencer returns to idle.
// the next frame is accepted while the last word still waits in the output
// register.
// a stalled receiver holds the sequencer before loading the next word.
// reset: phase and previous frame cleared, step_ratio set to one, no words
// pending; write step_ratio only while no frame is in progress.
`timescale 1ns / 1ps
`default_nettype none
module stereo_linear_resampler
    import slr_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    slr_frame_if.sink    samples,
    slr_result_if.source results,
    slr_cfg_if.sink      cfg
);

    localparam int PHASE_BITS = FRAC_BITS + 4;

    slr_cmd_t  cmd;
    slr_stat_t stat;

    slr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    slr_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .PHASE_BITS  (PHASE_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .results (results),
        .cfg     (cfg),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule
`default_nettype wire

### design/slr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module slr_ctrl
    import slr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire slr_stat_t stat,
    output slr_cmd_t       cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (stat.phase_lt_one && (cnt_reg != CNT_BITS'(MAX_OUTS)))
                begin
                    cmd.mul    = 1'b1;
                    cnt_next   = cnt_reg + CNT_BITS'(1);
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                // phase was advanced already, so it tells whether another output follows
                cmd.last = !stat.phase_lt_one || (cnt_reg == CNT_BITS'(MAX_OUTS));
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_RUN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### design/slr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module slr_datapath
    import slr_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16,
    parameter int PHASE_BITS  = 20
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    slr_frame_if.sink     samples,
    slr_result_if.source  results,
    slr_cfg_if.sink       cfg,
    input  wire slr_cmd_t cmd,
    output slr_stat_t     stat
);

    localparam int ACC_BITS  = PHASE_BITS + 1;
    localparam int DIFF_BITS = SAMPLE_BITS + 1;
    localparam int PROD_BITS = DIFF_BITS + FRAC_BITS + 1;
    localparam int PART_BITS = PROD_BITS - FRAC_BITS;
    localparam logic [ACC_BITS-1:0] ONE = ACC_BITS'(1) << FRAC_BITS;

    logic [PHASE_BITS-1:0]        step_reg;
    logic [ACC_BITS-1:0]          phase_reg, phase_next;
    logic signed [SAMPLE_BITS-1:0] prev_l_reg, prev_r_reg;
    logic signed [SAMPLE_BITS-1:0] new_l_reg, new_r_reg;
    logic signed [DIFF_BITS-1:0]  diff_l_reg, diff_r_reg;
    logic signed [PROD_BITS-1:0]  prod_l_reg, prod_r_reg;
    logic signed [SAMPLE_BITS-1:0] out_l_reg, out_r_reg;
    logic                         out_last_reg;
    logic                         out_valid_reg;

    logic signed [FRAC_BITS+1-1:0] frac_s;
    logic signed [PART_BITS-1:0]   part_l, part_r;
    logic signed [PART_BITS-1:0]   sum_l, sum_r;

    assign cfg.ready = 1'b1;

    assign stat.phase_lt_one = phase_reg < ONE;
    assign stat.out_free     = !out_valid_reg || results.ready;

    // phase is below one whenever it is multiplied, so only the fraction matters
    assign frac_s = $signed({1'b0, phase_reg[FRAC_BITS-1:0]});

    // arithmetic shift rounds toward minus infinity
    assign part_l = PART_BITS'(prod_l_reg >>> FRAC_BITS);
    assign part_r = PART_BITS'(prod_r_reg >>> FRAC_BITS);
    assign sum_l  = PART_BITS'(prev_l_reg) + part_l;
    assign sum_r  = PART_BITS'(prev_r_reg) + part_r;

    always_comb
    begin
        phase_next = phase_reg;
        if (cmd.mul)
        begin
            phase_next = phase_reg + ACC_BITS'(step_reg);
        end
        else if (cmd.finish)
        begin
            phase_next = (phase_reg >= ONE) ? (phase_reg - ONE) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= PHASE_BITS'(ONE);
            phase_reg     <= '0;
            prev_l_reg    <= '0;
            prev_r_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                step_reg <= cfg.step_ratio;
            end
            phase_reg <= phase_next;
            if (cmd.finish)
            begin
                prev_l_reg <= new_l_reg;
                prev_r_reg <= new_r_reg;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            new_l_reg  <= samples.in_left;
            new_r_reg  <= samples.in_right;
            diff_l_reg <= DIFF_BITS'(samples.in_left) - DIFF_BITS'(prev_l_reg);
            diff_r_reg <= DIFF_BITS'(samples.in_right) - DIFF_BITS'(prev_r_reg);
        end
        if (cmd.mul)
        begin
            prod_l_reg <= PROD_BITS'(diff_l_reg) * PROD_BITS'(frac_s);
            prod_r_reg <= PROD_BITS'(diff_r_reg) * PROD_BITS'(frac_s);
        end
        if (cmd.emit)
        begin
            out_l_reg    <= sum_l[SAMPLE_BITS-1:0];
            out_r_reg    <= sum_r[SAMPLE_BITS-1:0];
            out_last_reg <= cmd.last;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.out_left    = out_l_reg;
    assign results.out_right   = out_r_reg;
    assign results.last_of_run = out_last_reg;

endmodule
`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps
module tb;
    import slr_pkg::*;

    localparam int unsigned PHASE_ONE = 32'd1 << 16;
    localparam logic signed [23:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] SAMPLE_MIN = 24'sh800000;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEMS_PER_STEP = 36;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [23:0] left;
        logic signed [23:0] right;
        logic               last;
    } word_t;

    class resampler_scoreboard;
        bit [19:0]          step;
        bit [19:0]          phase;
        logic signed [23:0] prev_left;
        logic signed [23:0] prev_right;
        word_t              pending_words[$];
        int                 mismatches;

        function new();
            step = 20'h10000;
            phase = '0;
            prev_left = '0;
            prev_right = '0;
            mismatches = 0;
        endfunction

        function void set_step(bit [19:0] value);
            step = value;
        endfunction

        // prev + frac * (new - prev), product shifted down with floor
        function logic signed [23:0] blend(logic signed [23:0] a, logic signed [23:0] b,
                                           int unsigned frac);
            longint diff;
            longint prod;
            longint sum;
            diff = longint'(a);
            diff = longint'(b) - diff;
            prod = diff * longint'(frac);
            sum = longint'(a) + (prod >>> 16);
            return sum[23:0];
        endfunction

        function void note_frame(logic signed [23:0] new_left, logic signed [23:0] new_right);
            int unsigned ph;
            int          n;
            word_t       w;
            ph = phase;
            n = 0;
            while (ph < PHASE_ONE && n < MAX_OUTS) begin
                w.left = blend(prev_left, new_left, ph);
                w.right = blend(prev_right, new_right, ph);
                ph = ph + step;
                n++;
                w.last = (ph >= PHASE_ONE) || (n == MAX_OUTS);
                pending_words.push_back(w);
            end
            // saturating drop by one
            ph = (ph >= PHASE_ONE) ? ph - PHASE_ONE : 0;
            phase = ph[19:0];
            prev_left = new_left;
            prev_right = new_right;
        endfunction

        function void check_word(logic signed [23:0] l, logic signed [23:0] r, logic last);
            word_t w;
            if (pending_words.size() == 0) begin
                $display("%0t: word with nothing expected, left %0d right %0d last %0b",
                         $time, l, r, last);
                mismatches++;
                return;
            end
            w = pending_words.pop_front();
            if (l !== w.left) begin
                $display("%0t: out_left expected %0d got %0d", $time, w.left, l);
                mismatches++;
            end
            if (r !== w.right) begin
                $display("%0t: out_right expected %0d got %0d", $time, w.right, r);
                mismatches++;
            end
            if (last !== w.last) begin
                $display("%0t: last_of_run expected %0b got %0b", $time, w.last, last);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_words.size();
        endfunction
    endclass

    logic   clk;
    logic   rst_n;
    bit     quiet;
    bit     hold_request;
    int     hold_left;
    longint cycles;
    resampler_scoreboard sb;

    slr_frame_if  #(.W(24)) samples_if ();
    slr_result_if #(.W(24)) results_if ();
    slr_cfg_if    #(.W(20)) cfg_if ();

    stereo_linear_resampler #(
        .SAMPLE_BITS(24),
        .FRAC_BITS(16)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .samples(samples_if),
        .results(results_if),
        .cfg(cfg_if)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && results_if.valid && results_if.ready)
            sb.check_word(results_if.out_left, results_if.out_right, results_if.last_of_run);
    end

    // receiver: random stalls, or one long hold-off when asked
    initial
    begin
        results_if.ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                results_if.ready <= 1'b0;
            end
            else
                results_if.ready <= quiet || ($urandom_range(99) >= 14);
        end
    end

    function automatic logic signed [23:0] pick_sample();
        case ($urandom_range(7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return 24'($urandom_range(7)) - 24'sd4;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_frame(input logic signed [23:0] l, input logic signed [23:0] r);
        while (!quiet && $urandom_range(99) < 14)
        begin
            samples_if.valid <= 1'b0;
            @(posedge clk);
        end
        samples_if.valid <= 1'b1;
        samples_if.in_left <= l;
        samples_if.in_right <= r;
        do
            @(posedge clk);
        while (!samples_if.ready);
        sb.note_frame(l, r);
    endtask

    task automatic wait_drained();
        samples_if.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic write_step(input bit [19:0] value);
        wait_drained();
        // a frame with no words may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.step_ratio <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        sb.set_step(value);
    endtask

    initial
    begin
        bit [19:0] step_plan [10];
        int        p;
        int        k;
        sb = new();
        cycles = 0;
        quiet = 1'b0;
        hold_request = 1'b0;
        rst_n = 1'b0;
        samples_if.valid = 1'b0;
        samples_if.in_left = '0;
        samples_if.in_right = '0;
        cfg_if.valid = 1'b0;
        cfg_if.step_ratio = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unprimed start at the reset step, full-swing and near-zero frames
        send_frame(SAMPLE_MAX, SAMPLE_MIN);
        send_frame(SAMPLE_MIN, SAMPLE_MAX);
        send_frame(24'sd0, -24'sd1);
        send_frame(-24'sd1, 24'sd0);
        // zero step: eight words per frame, phase saturates at zero
        write_step(20'h00000);
        send_frame(SAMPLE_MIN, SAMPLE_MAX);
        send_frame(SAMPLE_MAX, SAMPLE_MIN);
        // eighth step: eight words landing exactly on one
        write_step(20'h02000);
        send_frame(SAMPLE_MAX, SAMPLE_MIN);
        send_frame(SAMPLE_MIN, SAMPLE_MAX);
        send_frame(24'sd1, -24'sd1);
        // step above one: some frames enter with phase at or above one
        write_step(20'h18000);
        send_frame(24'sd1000, -24'sd1000);
        send_frame(-24'sd3, 24'sd7);
        send_frame(SAMPLE_MAX, SAMPLE_MIN);
        send_frame(24'sd5, -24'sd5);
        // largest step: one word, then two silent frames
        write_step(20'hFFFFF);
        send_frame(SAMPLE_MIN, SAMPLE_MAX);
        send_frame(24'sd2, 24'sd3);
        send_frame(SAMPLE_MAX, SAMPLE_MAX);
        // inexact fraction, rounding on both signs
        write_step(20'h0AAAA);
        send_frame(SAMPLE_MAX, SAMPLE_MIN);
        send_frame(SAMPLE_MIN, SAMPLE_MAX);
        send_frame(-24'sd7, 24'sd7);

        step_plan = '{20'h10000, 20'h02000, 20'h0, 20'h0, 20'h80000,
                      20'h00000, 20'hFFFFF, 20'h0, 20'h0, 20'h0C000};
        step_plan[2] = 20'($urandom_range(524288, 8192));
        step_plan[3] = 20'($urandom_range(524288, 8192));
        step_plan[7] = 20'($urandom);
        step_plan[8] = 20'($urandom_range(65536, 8192));
        for (p = 0; p < 10; p++)
        begin
            write_step(step_plan[p]);
            quiet = (p == 3);
            // upsampling with a blocked receiver fills the block
            if (p == 1)
                hold_request = 1'b1;
            for (k = 0; k < ITEMS_PER_STEP; k++)
            begin
                if (p == 5 && k == ITEMS_PER_STEP / 2)
                    wait_drained();
                send_frame(pick_sample(), pick_sample());
            end
        end
        quiet = 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
